// File: rtl/core/ssoi_pkg.sv
`default_nettype none
package ssoi_pkg;

  localparam int LEFT_W     = 24;
  localparam int RIGHT_W    = 24;
  localparam int DT_W       = 21;
  localparam int GAIN_W     = 16;
  localparam int ICR_W      = 20;
  localparam int CFG_IDX_W  = 8;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 192;
  localparam int DIV_BITS   = 41;
  localparam int SQRT_STEPS = 24;
  localparam int GUARD_BITS = 8;

  localparam logic signed [31:0] KINV_Q30   = 32'sd652032874;
  localparam logic signed [31:0] INV2PI_Q21 = 32'sd333772;

  localparam logic [CFG_IDX_W-1:0] REG_WHEEL_GAIN = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ICR_OFFSET = 8'd1;

  typedef enum logic [4:0] {
    S_IDLE, S_MUL_V, S_MUL_W, S_MUL_K, S_CINIT, S_CORDIC, S_VEL, S_VX2, S_VY2,
    S_SQINIT, S_SQRT, S_DX, S_DY, S_ACCY, S_WDT, S_LO, S_HI, S_UPDATE
  } state_t;

  typedef struct packed {
    logic       load;
    state_t     op;
    logic [5:0] step;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_busy;
  } sts_t;

  function automatic logic [31:0] atan_val(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0: r = 32'h20000000;  5'd1: r = 32'h12E4051E;  5'd2: r = 32'h09FB385B;
      5'd3: r = 32'h051111D4;  5'd4: r = 32'h028B0D43;  5'd5: r = 32'h0145D7E1;
      5'd6: r = 32'h00A2F61E;  5'd7: r = 32'h00517C55;  5'd8: r = 32'h0028BE53;
      5'd9: r = 32'h00145F2F;  5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3; 5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D; 5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518; 5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146; 5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029; 5'd25: r = 32'h00000014; 5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005; 5'd28: r = 32'h00000003; 5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/ssoi_ctrl.sv
`default_nettype none
module ssoi_ctrl #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire ssoi_pkg::sts_t sts,
  output ssoi_pkg::cmd_t     cmd
);
  import ssoi_pkg::*;

  state_t     state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = '0;
    case (state_r)
      S_IDLE:   if (in_tvalid) state_nxt = S_MUL_V;
      S_MUL_V:  state_nxt = S_MUL_W;
      S_MUL_W:  state_nxt = S_MUL_K;
      S_MUL_K:  state_nxt = S_CINIT;
      S_CINIT:  state_nxt = S_CORDIC;
      S_CORDIC: begin
        if (cnt_r == 6'(CORDIC_STEPS - 1)) state_nxt = S_VEL;
        else cnt_nxt = cnt_r + 6'd1;
      end
      S_VEL:    state_nxt = S_VX2;
      S_VX2:    state_nxt = S_VY2;
      S_VY2:    state_nxt = S_SQINIT;
      S_SQINIT: state_nxt = S_SQRT;
      S_SQRT: begin
        if (cnt_r == 6'(SQRT_STEPS - 1)) state_nxt = S_DX;
        else cnt_nxt = cnt_r + 6'd1;
      end
      S_DX:     state_nxt = S_DY;
      S_DY:     state_nxt = S_ACCY;
      S_ACCY:   state_nxt = S_WDT;
      S_WDT:    if (sts.div_done) state_nxt = S_LO;
      S_LO:     state_nxt = S_HI;
      S_HI:     state_nxt = S_UPDATE;
      S_UPDATE: if (!sts.out_busy) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready = (state_r == S_IDLE);
    cmd.load  = (state_r == S_IDLE) && in_tvalid;
    cmd.op    = state_r;
    cmd.step  = cnt_r;
  end

  a_cordic_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CORDIC && cnt_r == 6'd0) |-> $past(state_r) == S_CINIT)
    else $error("CORDIC entered without initialization");
  a_lo_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LO) |-> ($past(state_r) == S_WDT && $past(sts.div_done)))
    else $error("heading multiply started before the divider finished");
  a_update_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && $past(state_r) == S_UPDATE) |-> !$past(sts.out_busy))
    else $error("result written while the output register was occupied");

endmodule
`default_nettype wire

// File: rtl/core/ssoi_dpath.sv
`default_nettype none
module ssoi_dpath (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire ssoi_pkg::cmd_t                     cmd,
  output ssoi_pkg::sts_t                          sts,
  input  wire logic [ssoi_pkg::IN_DATA_W-1:0]     in_tdata,
  input  wire logic                               cfg_valid,
  input  wire logic [ssoi_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [ssoi_pkg::ICR_W-1:0]         cfg_data,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [ssoi_pkg::OUT_DATA_W-1:0]         out_tdata
);
  import ssoi_pkg::*;

  logic [GAIN_W-1:0]        gain_r;
  logic [ICR_W-1:0]         icr_r;
  logic signed [24:0]       sum_r, diff_r;
  logic [DT_W-1:0]          dt_r;
  logic signed [23:0]       v_r;
  logic signed [57:0]       p_r, lo_r;
  logic signed [21:0]       ahi_r;
  logic [DIV_BITS-1:0]      dnum_r;
  logic [ICR_W-1:0]         drem_r;
  logic                     dneg_r, dbusy_r;
  logic [5:0]               dcnt_r;
  logic signed [33:0]       x_r, y_r, z_r;
  logic signed [23:0]       vx_r, vy_r;
  logic [46:0]              sq_r;
  logic [47:0]              sn_r, sres_r;
  logic signed [31:0]       px_r, py_r;
  logic [31:0]              hd_r;
  logic                     out_valid_r;
  logic [OUT_DATA_W-1:0]    out_data_r;

  logic signed [25:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [57:0] mul_p;
  logic               is_mul;
  logic [ICR_W-1:0]   icr_eff;
  logic [ICR_W:0]     dtrial;
  logic               dge;
  logic signed [23:0] w_sat;
  logic signed [57:0] sh15, sh22;
  logic signed [23:0] v_sat;
  logic signed [57:0] pmag;
  logic signed [33:0] x0, z0, xs, ys, at;
  logic signed [33:0] xg, yg;
  logic signed [23:0] vx_sat, vy_sat;
  logic [47:0]        sbit, strial;
  logic [5:0]         sshamt;
  logic signed [57:0] dsh;
  logic signed [32:0] psum;
  logic signed [31:0] pos_sat;
  logic signed [63:0] th_tot;
  logic [31:0]        hd_nxt;
  logic [22:0]        mag;

  assign is_mul = cmd.op inside {S_MUL_V, S_MUL_W, S_MUL_K, S_VX2, S_VY2, S_DX, S_DY,
                                 S_WDT, S_LO, S_HI};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      S_MUL_V: begin mul_a = 26'(sum_r);  mul_b = 32'(signed'({1'b0, gain_r})); end
      S_MUL_W: begin mul_a = 26'(diff_r); mul_b = 32'(signed'({1'b0, gain_r})); end
      S_MUL_K: begin mul_a = 26'(v_r);    mul_b = KINV_Q30; end
      S_VX2:   begin mul_a = 26'(vx_r);   mul_b = 32'(vx_r); end
      S_VY2:   begin mul_a = 26'(vy_r);   mul_b = 32'(vy_r); end
      S_DX:    begin mul_a = 26'(vx_r);   mul_b = 32'(signed'({1'b0, dt_r})); end
      S_DY:    begin mul_a = 26'(vy_r);   mul_b = 32'(signed'({1'b0, dt_r})); end
      S_WDT:   begin mul_a = 26'(w_sat);  mul_b = 32'(signed'({1'b0, dt_r})); end
      S_LO:    begin mul_a = signed'({3'b000, p_r[22:0]}); mul_b = INV2PI_Q21; end
      S_HI:    begin mul_a = 26'(ahi_r);  mul_b = INV2PI_Q21; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
    mul_p = 58'(mul_a) * 58'(mul_b);
  end

  // Divider: restoring, one quotient bit per cycle on the magnitude.
  assign icr_eff = (icr_r == '0) ? ICR_W'(1) : icr_r;
  assign dtrial  = {drem_r, dnum_r[DIV_BITS-1]};
  assign dge     = dtrial >= {1'b0, icr_eff};

  always_comb begin
    if (dneg_r) begin
      if (dnum_r > DIV_BITS'(8388608)) w_sat = -24'sd8388608;
      else w_sat = 24'(-signed'({1'b0, dnum_r}));
    end else begin
      if (dnum_r > DIV_BITS'(8388607)) w_sat = 24'sd8388607;
      else w_sat = 24'(dnum_r);
    end
  end

  always_comb begin
    sh15 = p_r >>> 15;
    if (sh15 > 58'sd8388607) v_sat = 24'sd8388607;
    else if (sh15 < -58'sd8388608) v_sat = -24'sd8388608;
    else v_sat = 24'(sh15);
    pmag = p_r[57] ? -p_r : p_r;
    sh22 = p_r >>> 22;
    x0   = 34'(sh22);
    z0   = 34'(signed'(hd_r));
    xs   = x_r >>> cmd.step[4:0];
    ys   = y_r >>> cmd.step[4:0];
    at   = 34'(signed'({2'b00, atan_val(cmd.step[4:0])}));
    xg   = x_r >>> GUARD_BITS;
    yg   = y_r >>> GUARD_BITS;
    if (xg > 34'sd8388607) vx_sat = 24'sd8388607;
    else if (xg < -34'sd8388608) vx_sat = -24'sd8388608;
    else vx_sat = 24'(xg);
    if (yg > 34'sd8388607) vy_sat = 24'sd8388607;
    else if (yg < -34'sd8388608) vy_sat = -24'sd8388608;
    else vy_sat = 24'(yg);
    sshamt = 6'd46 - {cmd.step[4:0], 1'b0};
    sbit   = 48'd1 << sshamt;
    strial = sres_r + sbit;
    dsh    = p_r >>> 20;
    psum   = (cmd.op == S_DY) ? 33'(px_r) + 33'(dsh) : 33'(py_r) + 33'(dsh);
    if (psum > 33'sd2147483647) pos_sat = 32'sh7FFFFFFF;
    else if (psum < -33'sd2147483648) pos_sat = 32'sh80000000;
    else pos_sat = 32'(psum);
    th_tot = (64'(p_r) <<< 23) + 64'(lo_r);
    hd_nxt = hd_r + th_tot[56:25];
    mag    = (sres_r > 48'd8388607) ? 23'h7FFFFF : sres_r[22:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r      <= 16'd16384;
      icr_r       <= 20'd19661;
      px_r        <= '0;
      py_r        <= '0;
      hd_r        <= '0;
      dbusy_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == REG_WHEEL_GAIN) gain_r <= cfg_data[GAIN_W-1:0];
        else if (cfg_index == REG_ICR_OFFSET) icr_r <= cfg_data;
      end
      if (cmd.op == S_MUL_K) begin
        dbusy_r <= 1'b1;
      end else if (dbusy_r && dcnt_r == 6'(DIV_BITS - 1)) begin
        dbusy_r <= 1'b0;
      end
      if (cmd.op == S_DY) px_r <= pos_sat;
      if (cmd.op == S_ACCY) py_r <= pos_sat;
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      if (cmd.op == S_UPDATE && !sts.out_busy) begin
        hd_r        <= hd_nxt;
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sum_r  <= 25'(signed'(in_tdata[23:0])) + 25'(signed'(in_tdata[47:24]));
      diff_r <= 25'(signed'(in_tdata[47:24])) - 25'(signed'(in_tdata[23:0]));
      dt_r   <= in_tdata[68:48];
    end
    if (is_mul) p_r <= mul_p;
    if (cmd.op == S_MUL_W) v_r <= v_sat;
    if (cmd.op == S_MUL_K) begin
      dnum_r <= {pmag[39:0], 1'b0};
      dneg_r <= p_r[57];
      drem_r <= '0;
      dcnt_r <= '0;
    end else if (dbusy_r) begin
      dnum_r <= {dnum_r[DIV_BITS-2:0], dge};
      drem_r <= dge ? ICR_W'(dtrial - {1'b0, icr_eff}) : dtrial[ICR_W-1:0];
      dcnt_r <= dcnt_r + 6'd1;
    end
    if (cmd.op == S_CINIT) begin
      y_r <= '0;
      if (z0 > 34'sd1073741824) begin
        z_r <= z0 - 34'sd2147483648;
        x_r <= -x0;
      end else if (z0 < -34'sd1073741824) begin
        z_r <= z0 + 34'sd2147483648;
        x_r <= -x0;
      end else begin
        z_r <= z0;
        x_r <= x0;
      end
    end
    if (cmd.op == S_CORDIC) begin
      if (!z_r[33]) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + at;
      end
    end
    if (cmd.op == S_VEL) begin
      vx_r <= vx_sat;
      vy_r <= vy_sat;
    end
    if (cmd.op == S_VY2) sq_r <= p_r[46:0];
    if (cmd.op == S_SQINIT) begin
      sn_r   <= {1'b0, sq_r} + {1'b0, p_r[46:0]};
      sres_r <= '0;
    end
    if (cmd.op == S_SQRT) begin
      if (sn_r >= strial) begin
        sn_r   <= sn_r - strial;
        sres_r <= (sres_r >> 1) + sbit;
      end else begin
        sres_r <= sres_r >> 1;
      end
    end
    if (cmd.op == S_LO) ahi_r <= p_r[44:23];
    if (cmd.op == S_HI) lo_r <= p_r;
    if (cmd.op == S_UPDATE && !sts.out_busy) begin
      out_data_r <= {1'b0, mag, w_sat, vy_r, vx_r, hd_nxt, py_r, px_r};
    end
  end

  assign sts.div_done = !dbusy_r;
  assign sts.out_busy = out_valid_r && !out_tready;
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;

endmodule
`default_nettype wire

// File: rtl/core/skid_steer_odometry_integrator.sv
// Each accepted item passes through the CORDIC iterations, a 24-step square root and the
// shared multiplier steps before out_tvalid rises. The next item is accepted only after the
// last one is written to the output register; the divider runs beside the CORDIC and
// adds waiting only when CORDIC_STEPS is below 9.
// A finished result waits in an output register while the next item is accepted.
// Synchronous active-low reset zeroes the pose and restores both register defaults.
`default_nettype none
module skid_steer_odometry_integrator #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // left_speed[23:0], right_speed[47:24], elapsed_time[68:48], zero pad
  input  wire logic [ssoi_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // pos_x[31:0], pos_y[63:32], heading_out[95:64], world_vel_x[119:96],
  // world_vel_y[143:120], yaw_rate[167:144], speed_mag[190:168], zero pad
  output logic [ssoi_pkg::OUT_DATA_W-1:0]        out_tdata,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [ssoi_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [ssoi_pkg::ICR_W-1:0]        cfg_data
);
  import ssoi_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  ssoi_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ssoi_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

// File: sim/tb_skid_steer_odometry_integrator.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_skid_steer_odometry_integrator;
  import ssoi_pkg::*;

  localparam int CORDIC_N = 16;
  localparam int LIMIT_CYCLES = 1000000;

  typedef struct {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic [31:0]        hdg;
    logic signed [23:0] vx;
    logic signed [23:0] vy;
    logic signed [23:0] yaw;
    logic [22:0]        mag;
  } pose_t;

  class odometry_scoreboard;
    longint x_pos, y_pos;
    logic [31:0] heading;
    longint gain, icr;
    pose_t pose_q[$];
    int errors, checked, noted;
    longint arctan[CORDIC_N];

    function new();
      arctan = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
                 32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
                 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
                 32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D};
      x_pos = 0; y_pos = 0; heading = 0;
      gain = 16384; icr = 19661;
      errors = 0; checked = 0; noted = 0;
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [ICR_W-1:0] val);
      if (idx == REG_WHEEL_GAIN) gain = val[GAIN_W-1:0];
      else if (idx == REG_ICR_OFFSET) icr = val;
    endfunction

    function void note_input(logic signed [23:0] vl, logic signed [23:0] vr,
                             logic [20:0] dt);
      longint v, w, z, x, y, xs, ys, vx, vy, dth, div;
      longint unsigned sq, root, bitv;
      pose_t p;
      v = clip((gain * (longint'(vl) + longint'(vr))) >>> 15, -8388608, 8388607);
      div = (icr == 0) ? 1 : icr;
      w = clip((2 * gain * (longint'(vr) - longint'(vl))) / div, -8388608, 8388607);
      // Fold the heading into the CORDIC's convergence range by flipping the vector.
      z = heading[31] ? longint'(heading) - 64'sh100000000 : longint'(heading);
      x = (v * 652032874) >>> (30 - GUARD_BITS);
      y = 0;
      if (z > 64'sh40000000) begin
        z -= 64'sh80000000; x = -x;
      end else if (z < -64'sh40000000) begin
        z += 64'sh80000000; x = -x;
      end
      for (int i = 0; i < CORDIC_N; i++) begin
        xs = x >>> i; ys = y >>> i;
        if (z >= 0) begin
          x -= ys; y += xs; z -= arctan[i];
        end else begin
          x += ys; y -= xs; z += arctan[i];
        end
      end
      vx = clip(x >>> GUARD_BITS, -8388608, 8388607);
      vy = clip(y >>> GUARD_BITS, -8388608, 8388607);
      sq = vx * vx + vy * vy;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > sq) bitv >>= 2;
      while (bitv != 0) begin
        if (sq >= root + bitv) begin
          sq -= root + bitv;
          root = (root >> 1) + bitv;
        end else begin
          root >>= 1;
        end
        bitv >>= 2;
      end
      if (root > 8388607) root = 8388607;
      x_pos = clip(x_pos + ((vx * longint'(dt)) >>> 20), -64'sh80000000, 64'sh7FFFFFFF);
      y_pos = clip(y_pos + ((vy * longint'(dt)) >>> 20), -64'sh80000000, 64'sh7FFFFFFF);
      dth = (w * longint'(dt) * 333772) >>> 25;
      heading = heading + dth[31:0];
      p.px = x_pos[31:0]; p.py = y_pos[31:0]; p.hdg = heading;
      p.vx = vx[23:0]; p.vy = vy[23:0]; p.yaw = w[23:0]; p.mag = root[22:0];
      pose_q.push_back(p);
      noted++;
    endfunction

    function void report(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH result %0d %s: got %h expected %h", checked, what, got, want);
      errors++;
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] d);
      pose_t p;
      if (pose_q.size() == 0) begin
        report("unexpected result", d[31:0], 32'd0);
        return;
      end
      p = pose_q.pop_front();
      if (d[31:0] !== p.px) report("pos_x", d[31:0], p.px);
      if (d[63:32] !== p.py) report("pos_y", d[63:32], p.py);
      if (d[95:64] !== p.hdg) report("heading_out", d[95:64], p.hdg);
      if (d[119:96] !== p.vx) report("world_vel_x", d[119:96], p.vx);
      if (d[143:120] !== p.vy) report("world_vel_y", d[143:120], p.vy);
      if (d[167:144] !== p.yaw) report("yaw_rate", d[167:144], p.yaw);
      if (d[190:168] !== p.mag) report("speed_mag", d[190:168], p.mag);
      checked++;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ICR_W-1:0] cfg_data = '0;

  odometry_scoreboard odo = new();
  int cycles = 0;
  int hold_request = 0;
  bit burst_mode = 1'b1;

  always #5 clk = ~clk;

  skid_steer_odometry_integrator uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
    if (rst_n && in_tvalid && in_tready)
      odo.note_input(in_tdata[23:0], in_tdata[47:24], in_tdata[68:48]);
    if (rst_n && out_tvalid && out_tready) odo.check_result(out_tdata);
    if (rst_n && cfg_valid && cfg_ready) odo.write_reg(cfg_index, cfg_data);
  end

  // The receiver stalls on its own pattern; a hold request blocks it until its count runs out.
  always @(negedge clk) begin
    int phase;
    phase = cycles % 97;
    if (hold_request > 0) begin
      out_tready <= 1'b0;
      hold_request <= hold_request - 1;
    end else if (phase < 30) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [ICR_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_item(logic signed [23:0] vl, logic signed [23:0] vr, logic [20:0] dt);
    int gap;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {3'b000, dt, vr, vl};
    do @(posedge clk); while (!in_tready);
    gap = (burst_mode && $urandom_range(0, 5) == 0) ? $urandom_range(1, 70) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (odo.pose_q.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  function automatic logic [23:0] rand_speed();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 400000) - 200000;
      2: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
      default: return $urandom_range(0, 2000) - 1000;
    endcase
  endfunction

  function automatic logic [20:0] rand_dt();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 21'h1FFFFF : 21'd0;
      default: return $urandom_range(0, 60000);
    endcase
  endfunction

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset register values.
    send_item(24'sh000000, 24'sh000000, 21'd0);
    send_item(24'sh7FFFFF, 24'sh7FFFFF, 21'h1FFFFF);
    send_item(24'sh800000, 24'sh800000, 21'h1FFFFF);
    send_item(24'sh800000, 24'sh7FFFFF, 21'd1048576);
    send_item(24'sh7FFFFF, 24'sh800000, 21'd1048576);
    send_item(24'sh010000, 24'sh020000, 21'd100000);
    send_item(24'sh7FFFFF, 24'sh000000, 21'h1FFFFF);
    send_item(24'sh000000, 24'sh7FFFFF, 21'h0FFFFF);
    send_item(24'sh123456, 24'sh654321, 21'd12345);
    drain();
    // Zero center distance, an unknown register index and the largest gain.
    write_cfg(REG_ICR_OFFSET, '0);
    write_cfg(8'd7, 20'hABCDE);
    write_cfg(REG_WHEEL_GAIN, 20'hFFFF);
    send_item(24'sh000001, 24'sh000002, 21'd1000);
    send_item(24'sh7FFFFF, 24'sh800000, 21'h1FFFFF);
    send_item(24'sh7FFFFF, 24'sh7FFFFF, 21'h1FFFFF);
    send_item(24'sh800000, 24'sh800000, 21'h1FFFFF);
    drain();
    write_cfg(REG_ICR_OFFSET, 20'hFFFFF);
    write_cfg(REG_WHEEL_GAIN, '0);
    send_item(24'sh7FFFFF, 24'sh800000, 21'h1FFFFF);
    send_item(24'sh400000, 24'sh400001, 21'd5000);
    drain();

    // Straight run at full gain drives the position into saturation.
    write_cfg(REG_WHEEL_GAIN, 20'hFFFF);
    write_cfg(REG_ICR_OFFSET, 20'd19661);
    burst_mode = 1'b0;
    for (int i = 0; i < 150; i++) send_item(24'sh7FFFFF, 24'sh7FFFFF, 21'h1FFFFF);
    drain();

    // Random phases, each with its own register setting.
    burst_mode = 1'b1;
    for (int ph = 0; ph < 6; ph++) begin
      write_cfg(REG_WHEEL_GAIN, (ph == 0) ? 20'd16384 : $urandom_range(0, 65535));
      write_cfg(REG_ICR_OFFSET, (ph == 1) ? 20'd1 : $urandom_range(0, 1048575));
      if (ph == 2) hold_request = 600;
      for (int i = 0; i < 95; i++) send_item(rand_speed(), rand_speed(), rand_dt());
      drain();
    end

    $display("Ran %0d items through %0d results, covering gain and center distance extremes,",
             odo.noted, odo.checked);
    $display("position saturation, heading wrap and receiver back-pressure.");
    if (odo.errors == 0 && odo.pose_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
